// ----- src/qksd_pkg.sv -----
// Shared types and constants for the quadrature knob step decoder.
`default_nettype none
package qksd_pkg;

    localparam int unsigned TIMEOUT_W = 16;
    localparam int unsigned ELAPSED_W = 8;
    localparam int unsigned EVENT_W   = 3;
    localparam int unsigned MODE_W    = 2;

    localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 16'd1000;

    localparam logic [MODE_W-1:0] MODE_IDLE    = 2'd0;
    localparam logic [MODE_W-1:0] MODE_A_ARMED = 2'd1;
    localparam logic [MODE_W-1:0] MODE_B_ARMED = 2'd2;

    localparam logic [EVENT_W-1:0] EV_A_LED     = 3'd0;
    localparam logic [EVENT_W-1:0] EV_B_LED     = 3'd1;
    localparam logic [EVENT_W-1:0] EV_A_DONE    = 3'd2;
    localparam logic [EVENT_W-1:0] EV_B_DONE    = 3'd3;
    localparam logic [EVENT_W-1:0] EV_A_TIMEOUT = 3'd4;
    localparam logic [EVENT_W-1:0] EV_B_TIMEOUT = 3'd5;

    typedef struct packed {
        logic               valid;
        logic [EVENT_W-1:0] event_res;
    } result_t;

    typedef struct packed {
        logic idle;
        logic time_zero;
    } core_status_t;

endpackage
`default_nettype wire

// ----- src/qksd_if.sv -----
// Valid/ready channel interfaces for input ticks and result events.
`default_nettype none
interface qksd_in_if;
    logic                          valid;
    logic                          ready;
    logic                          phase_a;
    logic                          phase_b;
    logic [qksd_pkg::ELAPSED_W-1:0] elapsed_ms;

    modport source (output valid, phase_a, phase_b, elapsed_ms, input ready);
    modport sink   (input valid, phase_a, phase_b, elapsed_ms, output ready);
endinterface

interface qksd_out_if;
    logic                         valid;
    logic                         ready;
    logic [qksd_pkg::EVENT_W-1:0] event_res;

    modport source (output valid, event_res, input ready);
    modport sink   (input valid, event_res, output ready);
endinterface
`default_nettype wire

// ----- src/quadrature_knob_step_decoder_top.sv -----
// Top level of the quadrature knob step decoder: config register, core, output skid.
`default_nettype none
// One input beat is one sample tick; the decoder takes a tick every clock while
// ready is high. Its event, if any, is registered into the output register, or
// into the single skid entry while the output stalls, so input ready drops only
// when both hold undelivered events. timeout_ms resets to 1000 and may be
// rewritten through cfg_we/cfg_wdata while no tick is in flight.
module quadrature_knob_step_decoder_top (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_we,
    input  wire logic [qksd_pkg::TIMEOUT_W-1:0] cfg_wdata,
    qksd_in_if.sink                             in_beat,
    qksd_out_if.source                          out_beat
);
    import qksd_pkg::*;

    logic [TIMEOUT_W-1:0] timeout_reg;
    logic                 accept;
    result_t              res;
    core_status_t         status;
    logic                 out_valid_reg, skid_valid_reg;
    logic [EVENT_W-1:0]   out_event_reg, skid_event_reg;

    assign in_beat.ready = !skid_valid_reg;
    assign accept        = in_beat.valid && !skid_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timeout_reg <= TIMEOUT_RESET;
        end
        else if (cfg_we)
        begin
            timeout_reg <= cfg_wdata;
        end
    end

    qksd_core u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (accept),
        .phase_a    (in_beat.phase_a),
        .phase_b    (in_beat.phase_b),
        .elapsed_ms (in_beat.elapsed_ms),
        .timeout_ms (timeout_reg),
        .result     (res),
        .status     (status)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (out_beat.ready)
            begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
        end
        else if (out_valid_reg && !out_beat.ready)
        begin
            skid_valid_reg <= res.valid;
        end
        else
        begin
            out_valid_reg <= res.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (out_beat.ready)
            begin
                out_event_reg <= skid_event_reg;
            end
        end
        else if (out_valid_reg && !out_beat.ready)
        begin
            skid_event_reg <= res.event_res;
        end
        else
        begin
            out_event_reg <= res.event_res;
        end
    end

    assign out_beat.valid     = out_valid_reg;
    assign out_beat.event_res = out_event_reg;

    a_skid_implies_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry held without output entry");

    a_idle_time_clear: assert property (@(posedge clk) disable iff (!rst_n)
        status.idle |-> status.time_zero)
        else $error("armed time not cleared while idle");

    a_stall_to_skid: assert property (@(posedge clk) disable iff (!rst_n)
        res.valid && out_valid_reg && !out_beat.ready && !skid_valid_reg
        |=> skid_valid_reg)
        else $error("stalled event not captured in skid entry");

endmodule
`default_nettype wire

// ----- src/qksd_core.sv -----
// Decoder state registers and single-pass next-state and event logic.
`default_nettype none
module qksd_core (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            accept,
    input  wire logic                            phase_a,
    input  wire logic                            phase_b,
    input  wire logic [qksd_pkg::ELAPSED_W-1:0]  elapsed_ms,
    input  wire logic [qksd_pkg::TIMEOUT_W-1:0]  timeout_ms,
    output qksd_pkg::result_t                    result,
    output qksd_pkg::core_status_t               status
);
    import qksd_pkg::*;

    logic [MODE_W-1:0]    mode_reg, mode_next;
    logic                 last_a_reg, last_b_reg;
    logic [TIMEOUT_W-1:0] time_reg, time_next;
    logic                 a_chg, b_chg, lead_chg, other_chg;
    logic [TIMEOUT_W:0]   sum;
    logic [TIMEOUT_W-1:0] sat;
    result_t              res;

    assign a_chg = phase_a ^ last_a_reg;
    assign b_chg = phase_b ^ last_b_reg;
    assign lead_chg  = (mode_reg == MODE_A_ARMED) ? a_chg : b_chg;
    assign other_chg = (mode_reg == MODE_A_ARMED) ? b_chg : a_chg;
    assign sum = {1'b0, time_reg} + {{(TIMEOUT_W+1-ELAPSED_W){1'b0}}, elapsed_ms};
    assign sat = sum[TIMEOUT_W] ? {TIMEOUT_W{1'b1}} : sum[TIMEOUT_W-1:0];

    always_comb
    begin
        mode_next     = mode_reg;
        time_next     = time_reg;
        res.valid     = 1'b0;
        res.event_res = EV_A_LED;
        unique case (mode_reg)
            MODE_IDLE:
            begin
                if (phase_a != phase_b)
                begin
                    if (a_chg && !b_chg)
                    begin
                        res.valid     = 1'b1;
                        res.event_res = EV_A_LED;
                        mode_next     = MODE_A_ARMED;
                        time_next     = '0;
                    end
                    else if (b_chg && !a_chg)
                    begin
                        res.valid     = 1'b1;
                        res.event_res = EV_B_LED;
                        mode_next     = MODE_B_ARMED;
                        time_next     = '0;
                    end
                end
            end
            MODE_A_ARMED, MODE_B_ARMED:
            begin
                if (other_chg || lead_chg)
                begin
                    mode_next = MODE_IDLE;
                    time_next = '0;
                    if (other_chg)
                    begin
                        res.valid     = 1'b1;
                        res.event_res = (mode_reg == MODE_A_ARMED) ? EV_A_DONE : EV_B_DONE;
                    end
                end
                else
                begin
                    time_next = sat;
                    if (sat > timeout_ms)
                    begin
                        res.valid     = 1'b1;
                        res.event_res = (mode_reg == MODE_A_ARMED) ? EV_A_TIMEOUT
                                                                   : EV_B_TIMEOUT;
                    end
                end
            end
            default:
            begin
                mode_next = MODE_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= MODE_IDLE;
            last_a_reg <= 1'b0;
            last_b_reg <= 1'b0;
            time_reg   <= '0;
        end
        else if (accept)
        begin
            mode_reg   <= mode_next;
            last_a_reg <= phase_a;
            last_b_reg <= phase_b;
            time_reg   <= time_next;
        end
    end

    assign result.valid     = accept & res.valid;
    assign result.event_res = res.event_res;
    assign status.idle      = (mode_reg == MODE_IDLE);
    assign status.time_zero = (time_reg == '0);

endmodule
`default_nettype wire
